// ===== rtl/ubd_pkg.sv =====
// package for the uart baud divisor calculator
// holds widths, fsm state type and the prescaler code mapping; no dependencies

package ubd_pkg;

  localparam int unsigned BaudW    = 28;
  localparam int unsigned ClkW     = 32;
  localparam int unsigned WordW    = 16;
  localparam int unsigned CodeW    = 3;
  localparam int unsigned MsW      = 24;
  localparam int unsigned ErrW     = 32;
  localparam int unsigned DvdW     = 48;
  localparam int unsigned DvsW     = 32;
  localparam int unsigned IncLimitDef = 65535;
  localparam int unsigned MsPerSec = 1000;

  // prescaler codes
  localparam logic [CodeW-1:0] CodeDiv1 = 3'h5;
  localparam logic [CodeW-1:0] CodeDiv2 = 3'h4;
  localparam logic [CodeW-1:0] CodeDiv3 = 3'h3;
  localparam logic [CodeW-1:0] CodeDiv4 = 3'h2;
  localparam logic [CodeW-1:0] CodeDiv5 = 3'h1;
  localparam logic [CodeW-1:0] CodeDiv6 = 3'h0;
  localparam logic [CodeW-1:0] CodeDiv7 = 3'h6;

  typedef enum logic [4:0] {
    StIdle, StGcd1, StNum, StDen, StChk, StSclM, StSclN, StSclNum, StSclDen,
    StPre, StGcd2, StTnum, StTden, StMul, StAch, StMod, StMs, StDone
  } state_e;

  function automatic logic [CodeW-1:0] prescaler_code(input logic [2:0] d);
    logic [CodeW-1:0] c;
    c = CodeDiv1;
    case (d)
      3'd1: c = CodeDiv1;
      3'd2: c = CodeDiv2;
      3'd3: c = CodeDiv3;
      3'd4: c = CodeDiv4;
      3'd5: c = CodeDiv5;
      3'd6: c = CodeDiv6;
      3'd7: c = CodeDiv7;
      default: c = CodeDiv1;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/ubd_divider.sv =====
// restoring divider, one quotient bit per cycle
// depends on ubd_pkg for default widths

module ubd_divider #(
  parameter int unsigned DvdW = ubd_pkg::DvdW,
  parameter int unsigned DvsW = ubd_pkg::DvsW
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DvdW-1:0] dividend_i,
  input  logic [DvsW-1:0] divisor_i,
  output logic            done_o,
  output logic [DvdW-1:0] quotient_o,
  output logic [DvsW-1:0] remainder_o
);

  localparam int unsigned CntW = $clog2(DvdW + 1);

  logic [DvdW-1:0] quo_q, quo_d;
  logic [DvsW-1:0] rem_q, rem_d, dvs_q, dvs_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [DvsW:0]   rem_sh;
  logic [DvsW:0]   rem_sub;

  // one restoring step
  always_comb begin
    rem_sh  = {rem_q, quo_q[DvdW-1]};
    rem_sub = rem_sh - {1'b0, dvs_q};
    quo_d   = quo_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = CntW'(DvdW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!rem_sub[DvsW]) begin
        rem_d = rem_sub[DvsW-1:0];
        quo_d = {quo_q[DvdW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[DvsW-1:0];
        quo_d = {quo_q[DvdW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

// ===== rtl/uart_baud_divisor_calc.sv =====
// top level of the uart fractional baud divisor calculator
// depends on ubd_pkg and ubd_divider
//
// usage: present baud_rate_i and clock_hz_i with in_valid_i; the item is taken
// when in_ready_o is high. in_ready_o is high only while the sequencer idles
// and no result item is waiting on the out channel.
// one result item follows on the out channel with the prescaler code, the
// increment and modulator words, the millisecond tick count and the baud error.
// a zero baud rate or clock is treated as one.
// every division goes through one shared 48-bit restoring divider; two euclid
// gcd runs use one division per remainder step. an item takes one division per
// gcd step of both runs plus 8 to 12 further divisions.
// if the receiver stalls, the result is held in the output registers and no new
// item is taken until it is delivered.
// reset clears the sequencer and the output valid; no clearing pass is needed.

module uart_baud_divisor_calc #(
  parameter int unsigned IncLimit = ubd_pkg::IncLimitDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [ubd_pkg::BaudW-1:0]   baud_rate_i,
  input  logic [ubd_pkg::ClkW-1:0]    clock_hz_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [ubd_pkg::CodeW-1:0]   ref_div_code_o,
  output logic [ubd_pkg::WordW-1:0]   increment_o,
  output logic [ubd_pkg::WordW-1:0]   modulator_o,
  output logic [ubd_pkg::MsW-1:0]     one_ms_o,
  output logic [ubd_pkg::ErrW-1:0]    baud_error_o
);

  localparam int unsigned BW = ubd_pkg::BaudW;
  localparam int unsigned CW = ubd_pkg::ClkW;
  localparam int unsigned DvdW = ubd_pkg::DvdW;
  localparam int unsigned DvsW = ubd_pkg::DvsW;
  localparam logic [CW-1:0] Lim  = CW'(IncLimit);
  localparam logic [CW-1:0] Lim7 = CW'(IncLimit * 7);

  ubd_pkg::state_e state_q, state_d;

  logic [BW-1:0]   baud_q;
  logic [CW-1:0]   clk_q, a_q, b_q, num_q, den_q, m_q, tnum_q, tden_q;
  logic [2:0]      d_q;
  logic [DvdW-1:0] prod_q;
  logic            launched_q;
  logic            out_valid_q;
  logic [ubd_pkg::CodeW-1:0] code_q;
  logic [ubd_pkg::WordW-1:0] inc_q, mod_q;
  logic [ubd_pkg::MsW-1:0]   ms_q;
  logic [ubd_pkg::ErrW-1:0]  err_q;

  logic            div_start, div_done, is_div_state, gcd_skip;
  logic [DvdW-1:0] div_dvd, div_q;
  logic [DvsW-1:0] div_dvs, div_r;
  logic [CW-1:0]   q32, n_plus, s_val;
  logic [DvdW-1:0] diff;
  logic            accept, deliver;

  assign accept  = in_valid_i && in_ready_o;
  assign deliver = (state_q == ubd_pkg::StDone) && (!out_valid_q || out_ready_i);
  assign q32     = div_q[CW-1:0];
  assign n_plus  = q32 + 1'b1;
  assign s_val   = (m_q > n_plus) ? m_q : n_plus;
  assign gcd_skip = (b_q == '0);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ubd_pkg::StIdle:   if (accept) state_d = ubd_pkg::StGcd1;
      ubd_pkg::StGcd1:   if (gcd_skip) state_d = ubd_pkg::StNum;
      ubd_pkg::StNum:    if (div_done) state_d = ubd_pkg::StDen;
      ubd_pkg::StDen:    if (div_done) state_d = ubd_pkg::StChk;
      ubd_pkg::StChk: begin
        if (num_q > Lim7 || den_q > Lim) state_d = ubd_pkg::StSclM;
        else state_d = ubd_pkg::StPre;
      end
      ubd_pkg::StSclM:   if (div_done) state_d = ubd_pkg::StSclN;
      ubd_pkg::StSclN:   if (div_done) state_d = ubd_pkg::StSclNum;
      ubd_pkg::StSclNum: if (div_done) state_d = ubd_pkg::StSclDen;
      ubd_pkg::StSclDen: if (div_done) state_d = ubd_pkg::StPre;
      ubd_pkg::StPre:    if (div_done) state_d = ubd_pkg::StGcd2;
      ubd_pkg::StGcd2:   if (gcd_skip) state_d = ubd_pkg::StTnum;
      ubd_pkg::StTnum:   if (div_done) state_d = ubd_pkg::StTden;
      ubd_pkg::StTden:   if (div_done) state_d = ubd_pkg::StMul;
      ubd_pkg::StMul:    state_d = ubd_pkg::StAch;
      ubd_pkg::StAch:    if (div_done) state_d = ubd_pkg::StMod;
      ubd_pkg::StMod:    if (div_done) state_d = ubd_pkg::StMs;
      ubd_pkg::StMs:     if (div_done) state_d = ubd_pkg::StDone;
      ubd_pkg::StDone:   if (deliver) state_d = ubd_pkg::StIdle;
      default:           state_d = ubd_pkg::StIdle;
    endcase
  end

  // divider operand selection
  always_comb begin
    div_dvd      = '0;
    div_dvs      = a_q;
    is_div_state = 1'b1;
    unique case (state_q)
      ubd_pkg::StGcd1, ubd_pkg::StGcd2: begin
        div_dvd      = DvdW'(a_q);
        div_dvs      = b_q;
        is_div_state = !gcd_skip;
      end
      ubd_pkg::StNum, ubd_pkg::StTnum: div_dvd = DvdW'(clk_q);
      ubd_pkg::StDen:    div_dvd = DvdW'({baud_q, 4'b0000});
      ubd_pkg::StTden:   div_dvd = DvdW'({num_q[CW-5:0], 4'b0000});
      ubd_pkg::StSclM: begin
        div_dvd = DvdW'(num_q - 1'b1);
        div_dvs = Lim7;
      end
      ubd_pkg::StSclN: begin
        div_dvd = DvdW'(den_q - 1'b1);
        div_dvs = Lim;
      end
      ubd_pkg::StSclNum: begin
        div_dvd = DvdW'(num_q);
        div_dvs = m_q;
      end
      ubd_pkg::StSclDen: begin
        div_dvd = DvdW'(den_q);
        div_dvs = m_q;
      end
      ubd_pkg::StPre: begin
        div_dvd = DvdW'(num_q - 1'b1);
        div_dvs = Lim;
      end
      ubd_pkg::StAch: begin
        div_dvd = prod_q;
        div_dvs = tden_q;
      end
      ubd_pkg::StMod: begin
        div_dvd = DvdW'(num_q);
        div_dvs = DvsW'(d_q);
      end
      ubd_pkg::StMs: begin
        div_dvd = DvdW'(clk_q);
        div_dvs = DvsW'(d_q) * DvsW'(ubd_pkg::MsPerSec);
      end
      default: is_div_state = 1'b0;
    endcase
    div_start = is_div_state && !launched_q;
  end

  ubd_divider #(
    .DvdW(DvdW),
    .DvsW(DvsW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quotient_o (div_q),
    .remainder_o(div_r)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ubd_pkg::StIdle;
      launched_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (div_start) launched_q <= 1'b1;
      else if (div_done) launched_q <= 1'b0;
      if (deliver) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // datapath registers
  assign diff = (div_q >= DvdW'(baud_q)) ? div_q - DvdW'(baud_q) : DvdW'(baud_q) - div_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      baud_q <= (baud_rate_i == '0) ? BW'(1) : baud_rate_i;
      clk_q  <= (clock_hz_i == '0) ? CW'(1) : clock_hz_i;
      a_q    <= (clock_hz_i == '0) ? CW'(1) : clock_hz_i;
      b_q    <= {((baud_rate_i == '0) ? BW'(1) : baud_rate_i), 4'b0000};
    end
    if (state_q == ubd_pkg::StMul) prod_q <= DvdW'(tnum_q) * DvdW'(den_q[15:0]);
    if (div_done) begin
      unique case (state_q)
        ubd_pkg::StGcd1, ubd_pkg::StGcd2: begin
          a_q <= b_q;
          b_q <= div_r;
        end
        ubd_pkg::StNum:    num_q <= q32;
        ubd_pkg::StDen:    den_q <= q32;
        ubd_pkg::StSclM:   m_q <= n_plus;
        ubd_pkg::StSclN:   m_q <= s_val;
        ubd_pkg::StSclNum: num_q <= (q32 == '0) ? CW'(1) : q32;
        ubd_pkg::StSclDen: den_q <= (q32 == '0) ? CW'(1) : q32;
        ubd_pkg::StPre: begin
          d_q <= n_plus[2:0];
          a_q <= clk_q;
          b_q <= {num_q[CW-5:0], 4'b0000};
        end
        ubd_pkg::StTnum:   tnum_q <= q32;
        ubd_pkg::StTden:   tden_q <= q32;
        ubd_pkg::StAch:    err_q <= (diff[DvdW-1:ubd_pkg::ErrW] != '0) ? '1
                                     : diff[ubd_pkg::ErrW-1:0];
        ubd_pkg::StMod:    mod_q <= q32[ubd_pkg::WordW-1:0] - 1'b1;
        ubd_pkg::StMs:     ms_q <= q32[ubd_pkg::MsW-1:0];
        default: ;
      endcase
    end
    if (deliver) begin
      code_q <= ubd_pkg::prescaler_code(d_q);
      inc_q  <= den_q[ubd_pkg::WordW-1:0] - 1'b1;
    end
  end

  // take a new item only when idle and the last result has left
  assign in_ready_o     = (state_q == ubd_pkg::StIdle) && !out_valid_q;
  assign out_valid_o    = out_valid_q;
  assign ref_div_code_o = code_q;
  assign increment_o    = inc_q;
  assign modulator_o    = mod_q;
  assign one_ms_o       = ms_q;
  assign baud_error_o   = err_q;

endmodule
